@@ design/dstq_pkg.sv @@
// Shared constants, codes and a helper function for the deadline-sorted timer queue.
package dstq_pkg;

  localparam int unsigned TIMERS_DEF     = 16;
  localparam int unsigned DL_W           = 48;
  localparam int unsigned IVAL_W         = 32;
  localparam int unsigned ID_W           = 4;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned ACT_W          = 2;
  localparam logic [IVAL_W-1:0] MIN_PERIOD_RST = 32'd100000;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADD_OK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd4;

  // Saturating add on 48-bit tick values
  function automatic logic [DL_W-1:0] sat_add(input logic [DL_W-1:0] a,
                                              input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
  endfunction

endpackage

@@ design/dstq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module dstq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/deadline_sorted_timer_queue_unit.sv @@
// Deadline-sorted timer queue: sorted list and slot deadlines held in RAM, one sequencer.
//
// The queue keeps its sorted list in a RAM of {timer, deadline, periodic, interval}
// entries and each timer's last deadline in a second RAM; both have a registered read.
// One item is worked at a time. All list walks go through the single read port of the
// list RAM. An add of a timer that is not queued scans the list, walks to the insertion
// point, opens a gap and rereads the head; re-adding a queued timer also closes the gap
// it leaves. A delete of a queued timer scans the list, closes its gap and rereads the
// head. A tick reports a quiet tick when nothing is due, otherwise it gives one result
// per expiry and requeues periodic timers. A rejected add and a delete of an unqueued
// timer go straight to their result; an unknown action gives no result. A stalled
// result holds the sequencer at its last step; the next item is taken while the last
// result still waits.
module deadline_sorted_timer_queue_unit #(
  parameter int unsigned TIMERS = dstq_pkg::TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dstq_pkg::ACT_W-1:0]  in_action,
  input  logic [dstq_pkg::ID_W-1:0]   in_timer_id,
  input  logic                        in_periodic,
  input  logic [dstq_pkg::IVAL_W-1:0] in_interval,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dstq_pkg::KIND_W-1:0] out_kind,
  output logic [dstq_pkg::ID_W-1:0]   out_expired_id,
  output logic [dstq_pkg::DL_W-1:0]   out_deadline,
  output logic                        out_head_changed,
  output logic [dstq_pkg::DL_W-1:0]   out_next_deadline,
  output logic                        out_queue_empty,
  output logic                        out_last,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dstq_pkg::IVAL_W-1:0] cfg_min_period
);

  localparam int unsigned IDW = $clog2(TIMERS);
  localparam int unsigned CW  = $clog2(TIMERS + 1);
  localparam int unsigned XW  = (IDW > dstq_pkg::ID_W) ? IDW : dstq_pkg::ID_W;
  localparam int unsigned DLW = dstq_pkg::DL_W;
  localparam int unsigned IVW = dstq_pkg::IVAL_W;

  typedef struct packed {
    logic [IDW-1:0] id;
    logic [DLW-1:0] dl;
    logic           per;
    logic [IVW-1:0] ival;
  } ent_t;

  localparam int unsigned OW = $bits(ent_t);

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_SC_RD, S_SC_CK, S_MV_RD, S_MV_WR, S_REM_DONE, S_CALC,
    S_FI_RD, S_FI_CK, S_INS_WR, S_HD_RD, S_HD_CK, S_EX_CK, S_EMIT
  } st_t;

  st_t                        st_r;
  logic [dstq_pkg::ACT_W-1:0] op_r;
  logic [IDW-1:0]             id_r;
  logic [dstq_pkg::ID_W-1:0]  eid_r;
  logic                       per_r;
  logic [IVW-1:0]             ival_r;
  logic [DLW-1:0]             base_r;
  logic                       join_ok_r;
  logic [DLW-1:0]             join_dl_r;
  logic                       rm_ok_r;
  logic [CW-1:0]              pos_r;
  logic [CW-1:0]              i_r;
  logic [CW-1:0]              j_r;
  logic                       mv_left_r;
  logic [CW-1:0]              cnt_r;
  logic [DLW-1:0]             dl_r;
  logic [DLW-1:0]             exp_dl_r;
  logic [dstq_pkg::KIND_W-1:0] kind_r;
  logic                       prev_empty_r;
  logic [DLW-1:0]             prev_head_r;
  logic [DLW-1:0]             now_r;
  logic [TIMERS-1:0]          queued_r;
  logic [TIMERS-1:0]          sv_r;
  logic [TIMERS-1:0]          fired_r;
  ent_t                       head_r;
  logic [IVW-1:0]             min_period_r;

  logic                        out_valid_r;
  logic [dstq_pkg::KIND_W-1:0] out_kind_r;
  logic [dstq_pkg::ID_W-1:0]   out_id_r;
  logic [DLW-1:0]              out_dl_r;
  logic                        out_chg_r;
  logic [DLW-1:0]              out_next_r;
  logic                        out_empty_r;
  logic                        out_last_r;

  // RAM ports
  logic           ord_we;
  logic [IDW-1:0] ord_waddr;
  ent_t           ord_wdata;
  logic [IDW-1:0] ord_raddr;
  logic [OW-1:0]  ord_rdata;
  ent_t           rd_e;
  logic           slot_we;
  logic [IDW-1:0] slot_raddr;
  logic [DLW-1:0] slot_rdata;

  logic [XW-1:0]  in_id_x;
  logic [IDW-1:0] in_idx;
  logic           in_id_ok;
  logic [XW-1:0]  head_id_x;
  logic           head_due;
  logic           cur_empty;
  logic [DLW-1:0] cur_head;
  logic           out_free;
  logic [CW-1:0]  mv_src;
  logic [DLW-1:0] calc_dl;
  logic [DLW-1:0] per_base;
  logic [IVW-1:0] os_ival;
  logic           sc_hit;
  logic           sc_join;

  assign rd_e = ent_t'(ord_rdata);

  dstq_ram #(.WIDTH(OW), .DEPTH(TIMERS)) u_order_ram (
    .clk  (clk),
    .we   (ord_we),
    .waddr(ord_waddr),
    .wdata(ord_wdata),
    .raddr(ord_raddr),
    .rdata(ord_rdata)
  );

  dstq_ram #(.WIDTH(DLW), .DEPTH(TIMERS)) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(id_r),
    .wdata(calc_dl),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  // Decode timer number against the slot count
  assign in_id_x   = XW'(in_timer_id);
  assign in_idx    = in_id_x[IDW-1:0];
  assign in_id_ok  = {1'b0, in_id_x} < (XW + 1)'(TIMERS);
  assign head_id_x = XW'(head_r.id);

  // Head view and whether the head is due in this tick
  assign cur_empty = (cnt_r == '0);
  assign cur_head  = cur_empty ? '0 : head_r.dl;
  assign head_due  = !cur_empty && (head_r.dl <= now_r) && !fired_r[head_r.id];
  assign out_free  = !out_valid_r || !out_stall;

  // New deadline for add or periodic requeue
  assign os_ival  = (ival_r == '0) ? IVW'(1) : ival_r;
  assign per_base = (base_r != '0) ? base_r : (join_ok_r ? join_dl_r : now_r);
  always_comb begin
    if (op_r == dstq_pkg::ACT_TICK) begin
      calc_dl = dstq_pkg::sat_add(exp_dl_r, DLW'(ival_r));
    end else if (per_r) begin
      calc_dl = dstq_pkg::sat_add(per_base, DLW'(ival_r));
    end else begin
      calc_dl = dstq_pkg::sat_add(now_r, DLW'(os_ival));
    end
  end

  // Scan compare on the entry just read
  assign sc_hit  = (rd_e.id == id_r);
  assign sc_join = !join_ok_r && rd_e.per && (rd_e.ival == ival_r);
  assign mv_src  = mv_left_r ? (j_r + CW'(1)) : (j_r - CW'(1));

  // Drive RAM ports from the sequencer state
  always_comb begin
    ord_we     = 1'b0;
    ord_waddr  = j_r[IDW-1:0];
    ord_wdata  = rd_e;
    ord_raddr  = '0;
    slot_we    = 1'b0;
    slot_raddr = id_r;
    case (st_r)
      S_IDLE:  slot_raddr = in_idx;
      S_SC_RD: ord_raddr = i_r[IDW-1:0];
      S_FI_RD: ord_raddr = i_r[IDW-1:0];
      S_MV_RD: ord_raddr = mv_src[IDW-1:0];
      S_MV_WR: ord_we = 1'b1;
      S_CALC:  slot_we = 1'b1;
      S_INS_WR: begin
        ord_we    = 1'b1;
        ord_waddr = pos_r[IDW-1:0];
        ord_wdata = '{id: id_r, dl: dl_r, per: per_r, ival: ival_r};
      end
      default: ;
    endcase
  end

  // Sequencer, queue state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_r        <= '0;
      now_r        <= '0;
      queued_r     <= '0;
      sv_r         <= '0;
      fired_r      <= '0;
      min_period_r <= dstq_pkg::MIN_PERIOD_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        min_period_r <= cfg_min_period;
      end
      if (out_valid_r && !out_stall && st_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= in_action;
            id_r         <= in_idx;
            eid_r        <= in_timer_id;
            per_r        <= in_periodic;
            ival_r       <= in_interval;
            prev_empty_r <= cur_empty;
            prev_head_r  <= cur_head;
            join_ok_r    <= 1'b0;
            rm_ok_r      <= 1'b0;
            i_r          <= '0;
            case (in_action)
              dstq_pkg::ACT_ADD: begin
                if (!in_id_ok || (in_periodic && in_interval < min_period_r)) begin
                  kind_r   <= dstq_pkg::KIND_REJECT;
                  exp_dl_r <= '0;
                  st_r     <= S_EMIT;
                end else begin
                  kind_r <= dstq_pkg::KIND_ADD_OK;
                  st_r   <= S_BASE;
                end
              end
              dstq_pkg::ACT_DEL: begin
                kind_r   <= dstq_pkg::KIND_DEL;
                exp_dl_r <= '0;
                st_r     <= (in_id_ok && queued_r[in_idx]) ? S_SC_RD : S_EMIT;
              end
              dstq_pkg::ACT_TICK: begin
                now_r   <= dstq_pkg::sat_add(now_r, DLW'(1));
                fired_r <= '0;
                st_r    <= S_EX_CK;
              end
              default: ;
            endcase
          end
        end
        // capture the stored deadline, unwritten slots read as zero
        S_BASE: begin
          base_r <= sv_r[id_r] ? slot_rdata : '0;
          st_r   <= cur_empty ? S_CALC : S_SC_RD;
        end
        S_SC_RD: st_r <= S_SC_CK;
        // find the timer's position and the first queued periodic of equal period
        S_SC_CK: begin
          if (sc_hit) begin
            rm_ok_r <= 1'b1;
            pos_r   <= i_r;
          end else if (sc_join) begin
            join_ok_r <= 1'b1;
            join_dl_r <= rd_e.dl;
          end
          if (i_r + CW'(1) == cnt_r) begin
            if (sc_hit || rm_ok_r) begin
              mv_left_r <= 1'b1;
              j_r       <= sc_hit ? i_r : pos_r;
              if ((sc_hit ? i_r : pos_r) + CW'(1) < cnt_r) begin
                st_r <= S_MV_RD;
              end else begin
                st_r <= S_REM_DONE;
              end
            end else begin
              st_r <= S_CALC;
            end
          end else begin
            i_r  <= i_r + CW'(1);
            st_r <= S_SC_RD;
          end
        end
        S_MV_RD: st_r <= S_MV_WR;
        // advance the move by one entry after each read and write
        S_MV_WR: begin
          if (mv_left_r) begin
            if (j_r + CW'(2) < cnt_r) begin
              j_r  <= j_r + CW'(1);
              st_r <= S_MV_RD;
            end else begin
              st_r <= S_REM_DONE;
            end
          end else begin
            if (j_r > pos_r + CW'(1)) begin
              j_r  <= j_r - CW'(1);
              st_r <= S_MV_RD;
            end else begin
              st_r <= S_INS_WR;
            end
          end
        end
        S_REM_DONE: begin
          cnt_r          <= cnt_r - CW'(1);
          queued_r[id_r] <= 1'b0;
          case (op_r)
            dstq_pkg::ACT_ADD:  st_r <= S_CALC;
            dstq_pkg::ACT_TICK: st_r <= per_r ? S_CALC : S_HD_RD;
            default:            st_r <= S_HD_RD;
          endcase
        end
        // store the new deadline and start the insertion walk
        S_CALC: begin
          dl_r       <= calc_dl;
          sv_r[id_r] <= 1'b1;
          i_r        <= '0;
          pos_r      <= '0;
          if (op_r == dstq_pkg::ACT_ADD) begin
            exp_dl_r <= calc_dl;
          end
          st_r <= cur_empty ? S_INS_WR : S_FI_RD;
        end
        S_FI_RD: st_r <= S_FI_CK;
        S_FI_CK: begin
          if (rd_e.dl <= dl_r) begin
            if (i_r + CW'(1) == cnt_r) begin
              pos_r <= cnt_r;
              st_r  <= S_INS_WR;
            end else begin
              i_r  <= i_r + CW'(1);
              st_r <= S_FI_RD;
            end
          end else begin
            pos_r     <= i_r;
            j_r       <= cnt_r;
            mv_left_r <= 1'b0;
            st_r      <= S_MV_RD;
          end
        end
        S_INS_WR: begin
          cnt_r          <= cnt_r + CW'(1);
          queued_r[id_r] <= 1'b1;
          st_r           <= S_HD_RD;
        end
        S_HD_RD: st_r <= cur_empty ? S_EMIT : S_HD_CK;
        S_HD_CK: begin
          head_r <= rd_e;
          st_r   <= S_EMIT;
        end
        // expire the head or report a quiet tick
        S_EX_CK: begin
          if (head_due) begin
            prev_empty_r     <= 1'b0;
            prev_head_r      <= head_r.dl;
            fired_r[head_r.id] <= 1'b1;
            id_r             <= head_r.id;
            eid_r            <= head_id_x[dstq_pkg::ID_W-1:0];
            per_r            <= head_r.per;
            ival_r           <= head_r.ival;
            exp_dl_r         <= head_r.dl;
            kind_r           <= dstq_pkg::KIND_EXPIRE;
            pos_r            <= '0;
            j_r              <= '0;
            mv_left_r        <= 1'b1;
            st_r             <= (cnt_r > CW'(1)) ? S_MV_RD : S_REM_DONE;
          end else begin
            kind_r   <= dstq_pkg::KIND_IDLE;
            eid_r    <= '0;
            exp_dl_r <= '0;
            st_r     <= S_EMIT;
          end
        end
        // hand the result over once the output register is free
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_id_r    <= eid_r;
            out_dl_r    <= exp_dl_r;
            out_chg_r   <= (cur_empty != prev_empty_r) ||
                           (!cur_empty && head_r.dl != prev_head_r);
            out_next_r  <= cur_head;
            out_empty_r <= cur_empty;
            if (kind_r == dstq_pkg::KIND_EXPIRE && head_due) begin
              out_last_r <= 1'b0;
              st_r       <= S_EX_CK;
            end else begin
              out_last_r <= 1'b1;
              st_r       <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall          = (st_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_expired_id    = out_id_r;
  assign out_deadline      = out_dl_r;
  assign out_head_changed  = out_chg_r;
  assign out_next_deadline = out_next_r;
  assign out_queue_empty   = out_empty_r;
  assign out_last          = out_last_r;

  // Queue count matches the queued flags whenever no item is in flight
  a_cnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_IDLE |-> $countones(queued_r) == int'(cnt_r))
    else $error("queued count disagrees with queued flags");

  // Count never exceeds the slot count
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= int'(TIMERS))
    else $error("queue count overflow");

  // An expiry never reports a deadline in the future
  a_exp_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == dstq_pkg::KIND_EXPIRE |-> out_dl_r <= now_r)
    else $error("expiry of a timer not yet due");

  // An expiring timer is marked fired, so it expires at most once per tick
  a_fire_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EX_CK && head_due |=> fired_r[id_r])
    else $error("expired timer not marked");

endmodule

@@ dv/deadline_sorted_timer_queue_unit_tb.sv @@
// Self-checking testbench for the deadline-sorted timer queue: predictor, scoreboard, stimulus.
module deadline_sorted_timer_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DLW  = dstq_pkg::DL_W;
  localparam int unsigned IDW  = dstq_pkg::ID_W;
  localparam int unsigned IVW  = dstq_pkg::IVAL_W;
  localparam int unsigned ACTW = dstq_pkg::ACT_W;
  localparam int unsigned KW   = dstq_pkg::KIND_W;
  localparam logic [DLW-1:0] DL_MAX = {DLW{1'b1}};
  localparam int unsigned NSLOT = dstq_pkg::TIMERS_DEF;
  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam logic [ACTW-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [KW-1:0]  kind;
    logic [IDW-1:0] tid;
    logic [DLW-1:0] dl;
    logic           head_chg;
    logic [DLW-1:0] next_dl;
    logic           empty;
    logic           last;
  } timer_result_t;

  // Timer queue predictor with its own copy of the state and scoreboard of pending results
  class timer_queue_scoreboard;
    logic [IVW-1:0] min_period;
    logic [DLW-1:0] now_tick;
    logic [IDW-1:0] order_q[$];
    logic [DLW-1:0] deadline_of[NSLOT];
    logic [IVW-1:0] period_of[NSLOT];
    bit             is_periodic[NSLOT];
    bit             is_queued[NSLOT];
    timer_result_t  pending_results[$];
    int             mismatches;

    function void clear();
      min_period = dstq_pkg::MIN_PERIOD_RST;
      now_tick = '0;
      order_q.delete();
      pending_results.delete();
      for (int i = 0; i < NSLOT; i++) begin
        deadline_of[i] = '0;
        period_of[i] = '0;
        is_periodic[i] = 0;
        is_queued[i] = 0;
      end
      mismatches = 0;
    endfunction

    function logic [DLW-1:0] add_sat(logic [DLW-1:0] a, logic [DLW-1:0] b);
      logic [DLW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DLW] ? DL_MAX : s[DLW-1:0];
    endfunction

    function logic [DLW-1:0] head_dl();
      return order_q.size() == 0 ? '0 : deadline_of[order_q[0]];
    endfunction

    function void unlink(int t);
      if (!is_queued[t]) return;
      foreach (order_q[i])
        if (order_q[i] == t) begin
          order_q.delete(i);
          break;
        end
      is_queued[t] = 0;
    endfunction

    function void link(int t);
      int pos;
      pos = 0;
      if (is_queued[t]) return;
      while (pos < order_q.size() && deadline_of[order_q[pos]] <= deadline_of[t]) pos++;
      order_q.insert(pos, IDW'(t));
      is_queued[t] = 1;
    endfunction

    function void push_result(logic [KW-1:0] k, int t, logic [DLW-1:0] d,
                              bit was_empty, logic [DLW-1:0] old_head, bit last);
      timer_result_t r;
      bit empty;
      empty = order_q.size() == 0;
      r.kind = k;
      r.tid = IDW'(t);
      r.dl = d;
      r.head_chg = (empty != was_empty) || (!empty && head_dl() != old_head);
      r.next_dl = head_dl();
      r.empty = empty;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    // Predict the results of one accepted item
    function void note_item(logic [ACTW-1:0] act, logic [IDW-1:0] tid, logic per,
                            logic [IVW-1:0] ival);
      bit was_empty;
      logic [DLW-1:0] old_head, base, d;
      bit fired[NSLOT];
      int n, t;
      was_empty = order_q.size() == 0;
      old_head = head_dl();
      case (act)
        dstq_pkg::ACT_ADD: begin
          if (per && ival < min_period) begin
            push_result(dstq_pkg::KIND_REJECT, int'(tid), '0, was_empty, old_head, 1);
            return;
          end
          unlink(int'(tid));
          if (!per) begin
            if (ival == 0) ival = IVW'(1);
            is_periodic[tid] = 0;
            period_of[tid] = ival;
            deadline_of[tid] = add_sat(now_tick, DLW'(ival));
          end else begin
            is_periodic[tid] = 1;
            period_of[tid] = ival;
            base = deadline_of[tid];
            if (base == 0) begin
              base = now_tick;
              foreach (order_q[i])
                if (is_periodic[order_q[i]] && period_of[order_q[i]] == ival) begin
                  base = deadline_of[order_q[i]];
                  break;
                end
            end
            deadline_of[tid] = add_sat(base, DLW'(ival));
          end
          link(int'(tid));
          push_result(dstq_pkg::KIND_ADD_OK, int'(tid), deadline_of[tid], was_empty,
                      old_head, 1);
        end
        dstq_pkg::ACT_DEL: begin
          is_periodic[tid] = 0;
          unlink(int'(tid));
          push_result(dstq_pkg::KIND_DEL, int'(tid), '0, was_empty, old_head, 1);
        end
        dstq_pkg::ACT_TICK: begin
          for (int i = 0; i < NSLOT; i++) fired[i] = 0;
          n = 0;
          now_tick = add_sat(now_tick, DLW'(1));
          while (order_q.size() > 0 && n < 16) begin
            t = int'(order_q[0]);
            d = deadline_of[t];
            if (d > now_tick || fired[t]) break;
            was_empty = 0;
            old_head = head_dl();
            fired[t] = 1;
            unlink(t);
            if (is_periodic[t]) begin
              deadline_of[t] = add_sat(d, DLW'(period_of[t]));
              link(t);
            end
            push_result(dstq_pkg::KIND_EXPIRE, t, d, was_empty, old_head, 0);
            n++;
          end
          if (n == 0) push_result(dstq_pkg::KIND_IDLE, 0, '0, was_empty, old_head, 1);
          else pending_results[pending_results.size()-1].last = 1;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest pending one
    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.tid !== want.tid || got.dl !== want.dl ||
          got.head_chg !== want.head_chg || got.next_dl !== want.next_dl ||
          got.empty !== want.empty || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_periodic;
  logic [ACTW-1:0] in_action;
  logic [IDW-1:0] in_timer_id;
  logic [IVW-1:0] in_interval;
  logic out_valid, out_stall;
  logic [KW-1:0] out_kind;
  logic [IDW-1:0] out_expired_id;
  logic [DLW-1:0] out_deadline, out_next_deadline;
  logic out_head_changed, out_queue_empty, out_last;
  logic cfg_valid, cfg_ready;
  logic [IVW-1:0] cfg_min_period;

  timer_queue_scoreboard sb;
  int send_idle_pct, recv_idle_pct, cycle_count;

  deadline_sorted_timer_queue_unit dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL deadline_sorted_timer_queue_unit");
      $finish;
    end
  end

  // Sample results at the rising edge
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_kind, out_expired_id, out_deadline, out_head_changed,
                        out_next_deadline, out_queue_empty, out_last});

  // Stall the result side at random
  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

  // Valid stays high after the accepting edge until the caller drives the next cycle
  task automatic send_item(logic [ACTW-1:0] act, logic [IDW-1:0] tid, logic per,
                           logic [IVW-1:0] ival);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_timer_id <= tid;
    in_periodic <= per;
    in_interval <= ival;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, tid, per, ival);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_min_period(logic [IVW-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_min_period <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.min_period = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Mostly adds and ticks on small intervals so timers keep expiring
  task automatic random_item(logic [IVW-1:0] per_lo);
    int r;
    logic [IVW-1:0] iv;
    r = $urandom_range(99);
    iv = ($urandom_range(9) == 0) ? $urandom : $urandom_range(12);
    if (r < 35) send_item(dstq_pkg::ACT_ADD, IDW'($urandom), 1'($urandom), iv);
    else if (r < 45) send_item(dstq_pkg::ACT_DEL, IDW'($urandom), 1'b0, $urandom);
    else if (r < 48) send_item(ACT_NONE, IDW'($urandom), 1'($urandom), $urandom);
    else if (r < 55)
      send_item(dstq_pkg::ACT_ADD, IDW'($urandom), 1'b1, per_lo + $urandom_range(3));
    else send_item(dstq_pkg::ACT_TICK, IDW'($urandom), 1'($urandom), $urandom);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0;
    in_valid = 0; in_action = '0; in_timer_id = '0; in_periodic = 0; in_interval = '0;
    cfg_valid = 0; cfg_min_period = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: idle tick, one-shot zero, reject, stale periodic, delete, unknown action
    send_item(dstq_pkg::ACT_TICK, 4'd0, 1'b0, 32'd0);
    send_item(dstq_pkg::ACT_ADD, 4'd0, 1'b0, 32'd0);
    send_item(dstq_pkg::ACT_ADD, 4'd15, 1'b0, 32'hFFFF_FFFF);
    send_item(dstq_pkg::ACT_ADD, 4'd1, 1'b1, 32'd5);
    send_item(dstq_pkg::ACT_ADD, 4'd2, 1'b1, dstq_pkg::MIN_PERIOD_RST);
    send_item(dstq_pkg::ACT_DEL, 4'd15, 1'b1, 32'd0);
    send_item(dstq_pkg::ACT_DEL, 4'd9, 1'b0, 32'd0);
    send_item(ACT_NONE, 4'd4, 1'b1, 32'd7);
    send_item(dstq_pkg::ACT_TICK, 4'd0, 1'b0, 32'd0);
    write_min_period(32'd1);
    send_item(dstq_pkg::ACT_ADD, 4'd3, 1'b1, 32'd2);
    send_item(dstq_pkg::ACT_ADD, 4'd4, 1'b1, 32'd2);
    send_item(dstq_pkg::ACT_ADD, 4'd5, 1'b0, 32'd2);
    send_item(dstq_pkg::ACT_ADD, 4'd6, 1'b0, 32'd3);
    for (int i = 0; i < 5; i++) send_item(dstq_pkg::ACT_TICK, 4'd0, 1'b0, 32'd0);
    send_item(dstq_pkg::ACT_DEL, 4'd3, 1'b0, 32'd0);
    send_item(dstq_pkg::ACT_ADD, 4'd3, 1'b1, 32'd1);
    send_item(dstq_pkg::ACT_TICK, 4'd0, 1'b0, 32'd0);
    send_item(dstq_pkg::ACT_ADD, 4'd7, 1'b1, 32'hFFFF_FFFF);
    write_min_period(32'hFFFF_FFFF);
    send_item(dstq_pkg::ACT_ADD, 4'd8, 1'b1, 32'hFFFF_FFFE);

    // Random: three idling phases, two min_period settings
    write_min_period(32'd2);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 27 : ph == 1 ? 58 : 0;
      recv_idle_pct = ph == 0 ? 58 : ph == 1 ? 27 : 0;
      if (ph == 2) write_min_period(32'd5);
      for (int i = 0; i < 26; i++) begin
        random_item(ph == 2 ? 32'd5 : 32'd2);
        if (ph == 1 && i == 15) drain();
      end
    end
    drain();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("PASS deadline_sorted_timer_queue_unit");
    else
      $display("FAIL deadline_sorted_timer_queue_unit");
    $finish;
  end
endmodule
